// ===== design/rau_pkg.sv =====
package rau_pkg;

  // Field widths on the stream ports are fixed; WORD_BITS only sets the internal word.
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned OP_W          = 3;
  localparam int unsigned FIELD_W       = 32;

  localparam int unsigned OFF_OP = 0;
  localparam int unsigned OFF_XN = OFF_OP + OP_W;
  localparam int unsigned OFF_XD = OFF_XN + FIELD_W;
  localparam int unsigned OFF_YN = OFF_XD + FIELD_W;
  localparam int unsigned OFF_YD = OFF_YN + FIELD_W;
  localparam int unsigned S_BITS = OFF_YD + FIELD_W;
  localparam int unsigned S_TDATA_W = ((S_BITS + 7) / 8) * 8;

  localparam int unsigned OFF_RN  = 0;
  localparam int unsigned OFF_RD  = OFF_RN + FIELD_W;
  localparam int unsigned OFF_ERR = OFF_RD + FIELD_W;
  localparam int unsigned M_BITS  = OFF_ERR + 1;
  localparam int unsigned M_TDATA_W = ((M_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_MUL    = 3'd2,
    OP_DIV    = 3'd3,
    OP_REDUCE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    MUL_XN_YD,
    MUL_XD_YN,
    MUL_XN_YN,
    MUL_XD_YD
  } mul_sel_e;

  typedef enum logic [1:0] {
    NUM_HOLD,
    NUM_LOAD,
    NUM_ADD,
    NUM_SUB
  } num_op_e;

  typedef enum logic [1:0] {
    DIV_GCD,
    DIV_NUM,
    DIV_DEN
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    num_op_e  num_op;
    logic     den_load;
    logic     gcd_init;
    logic     gcd_step;
    logic     div_start;
    div_sel_e div_sel;
    logic     qn_store;
    logic     qd_store;
    logic     err_set;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic a_zero;
    logic b_zero;
    logic div_done;
  } dp_status_t;

endpackage

// ===== design/rau_divider.sv =====
module rau_divider import rau_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WORD_BITS-1:0] dividend_i,
  input  logic [WORD_BITS-1:0] divisor_i,
  output logic [WORD_BITS-1:0] quo_o,
  output logic [WORD_BITS-1:0] rem_o,
  output logic                 done_o
);

  localparam int unsigned CNT_W = $clog2(WORD_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

  logic                 busy_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [WORD_BITS-1:0] d_q;
  logic [WORD_BITS-1:0] q_q, q_d;
  logic [WORD_BITS-1:0] r_q, r_d;
  logic [WORD_BITS:0]   shifted;
  logic [WORD_BITS:0]   diff;
  logic                 take;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    shifted = {r_q, q_q[WORD_BITS-1]};
    diff    = shifted - {1'b0, d_q};
    take    = !diff[WORD_BITS];
    r_d     = take ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
    q_d     = {q_q[WORD_BITS-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q <= divisor_i;
      q_q <= dividend_i;
      r_q <= '0;
    end else if (busy_q) begin
      q_q <= q_d;
      r_q <= r_d;
    end
  end

  assign quo_o  = q_q;
  assign rem_o  = r_q;
  assign done_o = done_q;

endmodule

// ===== design/rau_datapath.sv =====
module rau_datapath import rau_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_status_t           status_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [WORD_BITS-1:0] xn_i,
  input  logic [WORD_BITS-1:0] xd_i,
  input  logic [WORD_BITS-1:0] yn_i,
  input  logic [WORD_BITS-1:0] yd_i,
  output logic [WORD_BITS-1:0] res_num_o,
  output logic [WORD_BITS-1:0] res_den_o,
  output logic                 err_o
);

  op_e                  op_q;
  logic [WORD_BITS-1:0] xn_q, xd_q, yn_q, yd_q;
  logic [WORD_BITS-1:0] xn_mag, xd_mag;
  logic [WORD_BITS-1:0] ma, mb, prod_d, prod_q;
  logic [WORD_BITS-1:0] num_q, den_q;
  logic [WORD_BITS-1:0] a_q, b_q;
  logic                 err_q;
  logic [WORD_BITS-1:0] out_num_q, out_den_q;
  logic                 out_err_q;
  logic [WORD_BITS-1:0] div_a, div_b, quo, rem;
  logic                 div_done;

  // Magnitudes as unsigned words; the most negative value maps onto itself.
  assign xn_mag = xn_q[WORD_BITS-1] ? (~xn_q + 1'b1) : xn_q;
  assign xd_mag = xd_q[WORD_BITS-1] ? (~xd_q + 1'b1) : xd_q;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_XN_YD: begin ma = xn_q; mb = yd_q; end
      MUL_XD_YN: begin ma = xd_q; mb = yn_q; end
      MUL_XN_YN: begin ma = xn_q; mb = yn_q; end
      default:   begin ma = xd_q; mb = yd_q; end
    endcase
    prod_d = ma * mb;
  end

  always_comb begin
    case (cmd_i.div_sel)
      DIV_GCD: begin div_a = a_q;    div_b = b_q; end
      DIV_NUM: begin div_a = xn_mag; div_b = a_q; end
      DIV_DEN: begin div_a = xd_mag; div_b = a_q; end
      default: begin div_a = a_q;    div_b = b_q; end
    endcase
  end

  rau_divider #(
    .WORD_BITS(WORD_BITS)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i   (cmd_i.div_start),
    .dividend_i(div_a),
    .divisor_i (div_b),
    .quo_o     (quo),
    .rem_o     (rem),
    .done_o    (div_done)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_e'(op_i);
      xn_q <= xn_i;
      xd_q <= xd_i;
      yn_q <= yn_i;
      yd_q <= yd_i;
    end

    if (cmd_i.mul_en) prod_q <= prod_d;

    // Defaults to x so that unused codes and the zero gcd case pass it through.
    if (cmd_i.load) begin
      num_q <= xn_i;
    end else if (cmd_i.qn_store) begin
      num_q <= xn_q[WORD_BITS-1] ? (~quo + 1'b1) : quo;
    end else begin
      case (cmd_i.num_op)
        NUM_LOAD: num_q <= prod_q;
        NUM_ADD:  num_q <= num_q + prod_q;
        NUM_SUB:  num_q <= num_q - prod_q;
        default:  num_q <= num_q;
      endcase
    end

    if (cmd_i.load) begin
      den_q <= xd_i;
    end else if (cmd_i.qd_store) begin
      den_q <= xd_q[WORD_BITS-1] ? (~quo + 1'b1) : quo;
    end else if (cmd_i.den_load) begin
      den_q <= prod_q;
    end

    if (cmd_i.load)         err_q <= 1'b0;
    else if (cmd_i.err_set) err_q <= 1'b1;

    if (cmd_i.gcd_init) begin
      a_q <= xn_mag;
      b_q <= xd_mag;
    end else if (cmd_i.gcd_step) begin
      a_q <= b_q;
      b_q <= rem;
    end

    if (cmd_i.out_load) begin
      out_num_q <= num_q;
      out_den_q <= den_q;
      out_err_q <= err_q;
    end
  end

  assign status_o.op       = op_q;
  assign status_o.a_zero   = (a_q == '0);
  assign status_o.b_zero   = (b_q == '0);
  assign status_o.div_done = div_done;

  assign res_num_o = out_num_q;
  assign res_den_o = out_den_q;
  assign err_o     = out_err_q;

endmodule

// ===== design/rau_ctrl.sv =====
module rau_ctrl import rau_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_GCD_INIT,
    S_GCD_TEST,
    S_GCD_WAIT,
    S_QN_WAIT,
    S_QD_WAIT,
    S_FINISH
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q;
  logic    cross_add;

  assign cross_add = (status_i.op == OP_ADD) || (status_i.op == OP_SUB);

  always_comb begin
    state_d         = state_q;
    cmd_o.load      = 1'b0;
    cmd_o.mul_en    = 1'b0;
    cmd_o.mul_sel   = MUL_XN_YD;
    cmd_o.num_op    = NUM_HOLD;
    cmd_o.den_load  = 1'b0;
    cmd_o.gcd_init  = 1'b0;
    cmd_o.gcd_step  = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.div_sel   = DIV_GCD;
    cmd_o.qn_store  = 1'b0;
    cmd_o.qd_store  = 1'b0;
    cmd_o.err_set   = 1'b0;
    cmd_o.out_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status_i.op)
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_d = S_M1;
          OP_REDUCE:                      state_d = S_GCD_INIT;
          default:                        state_d = S_FINISH;
        endcase
      end
      S_M1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = (status_i.op == OP_MUL) ? MUL_XN_YN : MUL_XN_YD;
        state_d       = S_M2;
      end
      S_M2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = (status_i.op == OP_MUL) ? MUL_XD_YD : MUL_XD_YN;
        cmd_o.num_op  = NUM_LOAD;
        state_d       = S_M3;
      end
      S_M3: begin
        if (cross_add) begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MUL_XD_YD;
          cmd_o.num_op  = (status_i.op == OP_SUB) ? NUM_SUB : NUM_ADD;
          state_d       = S_M4;
        end else begin
          cmd_o.den_load = 1'b1;
          state_d        = S_FINISH;
        end
      end
      S_M4: begin
        cmd_o.den_load = 1'b1;
        state_d        = S_FINISH;
      end
      S_GCD_INIT: begin
        cmd_o.gcd_init = 1'b1;
        state_d        = S_GCD_TEST;
      end
      S_GCD_TEST: begin
        if (!status_i.b_zero) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_GCD;
          state_d         = S_GCD_WAIT;
        end else if (status_i.a_zero) begin
          cmd_o.err_set = 1'b1;
          state_d       = S_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_NUM;
          state_d         = S_QN_WAIT;
        end
      end
      S_GCD_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.gcd_step = 1'b1;
          state_d        = S_GCD_TEST;
        end
      end
      S_QN_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.qn_store  = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_DEN;
          state_d         = S_QD_WAIT;
        end
      end
      S_QD_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.qd_store = 1'b1;
          state_d        = S_FINISH;
        end
      end
      S_FINISH: begin
        // The output register is free, or its transaction completes this cycle.
        if (!out_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load)  out_valid_q <= 1'b1;
      else if (m_ready_i)  out_valid_q <= 1'b0;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = out_valid_q;

endmodule

// ===== design/rational_arithmetic_unit_top.sv =====
// Multiply and divide form two products in turn; add and subtract form a third and
// combine them, and unused codes return the loaded x unchanged. Reduce runs one Euclid
// remainder step per divider pass, then the two final quotients, or sets the error when
// both parts are zero; every step runs through one shared bit-serial divider.
// One transaction is in flight at a time; the next is accepted in the cycle after its
// result is loaded, and loading waits while the output register holds an unaccepted one.
// Reset is asynchronous and active low; it clears the controller and divider state.
module rational_arithmetic_unit_top import rau_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // operation[2:0], x_num[34:3], x_den[66:35], y_num[98:67], y_den[130:99], zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // res_num[31:0], res_den[63:32], zero_gcd_error[64], zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  dp_cmd_t              cmd;
  dp_status_t           status;
  logic [WORD_BITS-1:0] res_num, res_den;
  logic                 err;

  rau_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .s_valid_i(s_axis_tvalid_i),
    .s_ready_o(s_axis_tready_o),
    .m_valid_o(m_axis_tvalid_o),
    .m_ready_i(m_axis_tready_i),
    .status_i (status),
    .cmd_o    (cmd)
  );

  rau_datapath #(
    .WORD_BITS(WORD_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i    (cmd),
    .status_o (status),
    .op_i     (s_axis_tdata_i[OFF_OP +: OP_W]),
    .xn_i     (s_axis_tdata_i[OFF_XN +: WORD_BITS]),
    .xd_i     (s_axis_tdata_i[OFF_XD +: WORD_BITS]),
    .yn_i     (s_axis_tdata_i[OFF_YN +: WORD_BITS]),
    .yd_i     (s_axis_tdata_i[OFF_YD +: WORD_BITS]),
    .res_num_o(res_num),
    .res_den_o(res_den),
    .err_o    (err)
  );

  always_comb begin
    m_axis_tdata_o                        = '0;
    m_axis_tdata_o[OFF_RN +: FIELD_W]     = FIELD_W'($signed(res_num));
    m_axis_tdata_o[OFF_RD +: FIELD_W]     = FIELD_W'($signed(res_den));
    m_axis_tdata_o[OFF_ERR]               = err;
  end

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while a transaction is in flight");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> m_axis_tvalid_o)
    else $error("loaded result not presented on the output");

  a_div_reduce_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_done |-> status.op == OP_REDUCE)
    else $error("divider finished outside a reduce operation");

endmodule
